// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- src/lgdd_pkg.sv -----
// Shared types, constants and the microcode table of the lock graph deadlock detector.
package lgdd_pkg;

	// Default sizes of the graph
	localparam int NUM_PROCS_DEF = 8;
	localparam int NUM_LOCKS_DEF = 8;
	localparam int NUM_NODES_DEF = 16;

	// Fixed field widths
	localparam int FUNC_W = 3;
	localparam int ID_W   = 3;
	localparam int LOCK_W = 3;

	// Command codes
	localparam logic [FUNC_W-1:0] FUNC_REQUEST    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ALLOCATE   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_DEALLOCATE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_DETECT     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR      = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   proc_id;
		logic [LOCK_W-1:0] lock_num;
	} cmd_t;

	typedef struct packed {
		logic              cycle_found;
		logic [LOCK_W-1:0] victim_lock;
		logic              victim_valid;
	} result_t;

	// Datapath operations, one per microcode step
	typedef enum logic [4:0] {
		OP_NOP,
		OP_ZERO_SWEEP,
		OP_LATCH,
		OP_RESULT,
		OP_RD_P,
		OP_RD_L,
		OP_WR_P_SETL,
		OP_WR_L_SETP,
		OP_WR_P_CLRL,
		OP_WR_L_CLRP,
		OP_SWEEP_INIT,
		OP_RD_SWEEP,
		OP_WR_SWEEP_CLRP,
		OP_WR_P_ZERO,
		OP_DET_INIT,
		OP_START_ROOT,
		OP_RD_CUR,
		OP_SUCC,
		OP_TRACE_INIT,
		OP_TOUCH_TVAL,
		OP_RD_STACK,
		OP_LOAD_TVAL,
		OP_TOUCH_S,
		OP_PUSH,
		OP_RETIRE,
		OP_POP_RD,
		OP_POP_LOAD,
		OP_ROOT_INC
	} dp_op_t;

	// Jump conditions
	typedef enum logic [4:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_REQ_OK,
		C_ALLOC_OK,
		C_DEALLOC_OK,
		C_DETECT,
		C_CLEAR_OK,
		C_SWEEP_MORE,
		C_ROOT_END,
		C_ROOT_DONE,
		C_NO_SUCC,
		C_S_FRESH,
		C_S_NOT_ACTIVE,
		C_TVAL_IS_S,
		C_IDX_ZERO,
		C_D_ZERO
	} cond_t;

	// Status flags from the datapath to the sequencer
	typedef struct packed {
		logic req_ok;
		logic alloc_ok;
		logic dealloc_ok;
		logic detect;
		logic clear_ok;
		logic sweep_more;
		logic root_end;
		logic root_done;
		logic no_succ;
		logic s_fresh;
		logic s_not_active;
		logic tval_is_s;
		logic idx_zero;
		logic d_zero;
	} flags_t;

	localparam int UPC_W = 6;
	typedef logic [UPC_W-1:0] upc_t;

	typedef struct packed {
		dp_op_t op;
		cond_t  cond;
		upc_t   target;
	} ctrl_word_t;

	// Step addresses
	localparam upc_t U_ZERO      = 6'd0;
	localparam upc_t U_IDLE      = 6'd1;
	localparam upc_t U_RES       = 6'd7;
	localparam upc_t U_REQ       = 6'd8;
	localparam upc_t U_ALLOC     = 6'd10;
	localparam upc_t U_DEALLOC   = 6'd14;
	localparam upc_t U_CLR       = 6'd16;
	localparam upc_t U_CSWEEP    = 6'd17;
	localparam upc_t U_DET       = 6'd20;
	localparam upc_t U_ROOT      = 6'd21;
	localparam upc_t U_LOOP      = 6'd24;
	localparam upc_t U_TRACE     = 6'd29;
	localparam upc_t U_TRACE_END = 6'd33;
	localparam upc_t U_PUSH      = 6'd34;
	localparam upc_t U_FINISH    = 6'd35;
	localparam upc_t U_NEXT_ROOT = 6'd38;

	function automatic ctrl_word_t cw(input dp_op_t op, input cond_t cond, input upc_t target);
		ctrl_word_t w;
		w.op = op;
		w.cond = cond;
		w.target = target;
		return w;
	endfunction

	// Microcode ROM
	function automatic ctrl_word_t ucode(input upc_t pc);
		ctrl_word_t w;
		case (pc)
			6'd0:  w = cw(OP_ZERO_SWEEP,    C_SWEEP_MORE,   U_ZERO);
			6'd1:  w = cw(OP_LATCH,         C_NO_START,     U_IDLE);
			6'd2:  w = cw(OP_NOP,           C_REQ_OK,       U_REQ);
			6'd3:  w = cw(OP_NOP,           C_ALLOC_OK,     U_ALLOC);
			6'd4:  w = cw(OP_NOP,           C_DEALLOC_OK,   U_DEALLOC);
			6'd5:  w = cw(OP_NOP,           C_DETECT,       U_DET);
			6'd6:  w = cw(OP_NOP,           C_CLEAR_OK,     U_CLR);
			6'd7:  w = cw(OP_RESULT,        C_ALWAYS,       U_IDLE);
			6'd8:  w = cw(OP_RD_P,          C_NEVER,        U_IDLE);
			6'd9:  w = cw(OP_WR_P_SETL,     C_ALWAYS,       U_RES);
			6'd10: w = cw(OP_RD_L,          C_NEVER,        U_IDLE);
			6'd11: w = cw(OP_WR_L_SETP,     C_NEVER,        U_IDLE);
			6'd12: w = cw(OP_RD_P,          C_NEVER,        U_IDLE);
			6'd13: w = cw(OP_WR_P_CLRL,     C_ALWAYS,       U_RES);
			6'd14: w = cw(OP_RD_L,          C_NEVER,        U_IDLE);
			6'd15: w = cw(OP_WR_L_CLRP,     C_ALWAYS,       U_RES);
			6'd16: w = cw(OP_SWEEP_INIT,    C_NEVER,        U_IDLE);
			6'd17: w = cw(OP_RD_SWEEP,      C_NEVER,        U_IDLE);
			6'd18: w = cw(OP_WR_SWEEP_CLRP, C_SWEEP_MORE,   U_CSWEEP);
			6'd19: w = cw(OP_WR_P_ZERO,     C_ALWAYS,       U_RES);
			6'd20: w = cw(OP_DET_INIT,      C_NEVER,        U_IDLE);
			6'd21: w = cw(OP_NOP,           C_ROOT_END,     U_RES);
			6'd22: w = cw(OP_NOP,           C_ROOT_DONE,    U_NEXT_ROOT);
			6'd23: w = cw(OP_START_ROOT,    C_NEVER,        U_IDLE);
			6'd24: w = cw(OP_RD_CUR,        C_NEVER,        U_IDLE);
			6'd25: w = cw(OP_SUCC,          C_NO_SUCC,      U_FINISH);
			6'd26: w = cw(OP_NOP,           C_S_FRESH,      U_PUSH);
			6'd27: w = cw(OP_NOP,           C_S_NOT_ACTIVE, U_LOOP);
			6'd28: w = cw(OP_TRACE_INIT,    C_NEVER,        U_IDLE);
			6'd29: w = cw(OP_NOP,           C_TVAL_IS_S,    U_TRACE_END);
			6'd30: w = cw(OP_TOUCH_TVAL,    C_IDX_ZERO,     U_TRACE_END);
			6'd31: w = cw(OP_RD_STACK,      C_NEVER,        U_IDLE);
			6'd32: w = cw(OP_LOAD_TVAL,     C_ALWAYS,       U_TRACE);
			6'd33: w = cw(OP_TOUCH_S,       C_ALWAYS,       U_LOOP);
			6'd34: w = cw(OP_PUSH,          C_ALWAYS,       U_LOOP);
			6'd35: w = cw(OP_RETIRE,        C_D_ZERO,       U_NEXT_ROOT);
			6'd36: w = cw(OP_POP_RD,        C_NEVER,        U_IDLE);
			6'd37: w = cw(OP_POP_LOAD,      C_ALWAYS,       U_LOOP);
			6'd38: w = cw(OP_ROOT_INC,      C_ALWAYS,       U_ROOT);
			default: w = cw(OP_NOP,         C_ALWAYS,       U_IDLE);
		endcase
		return w;
	endfunction

endpackage

// ----- src/lgdd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lgdd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word; the read word appears in the next cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/lgdd_seq.sv -----
// Microcode sequencer: step counter, control ROM and conditional jumps.
module lgdd_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lgdd_pkg::flags_t    flags,
	output lgdd_pkg::dp_op_t    op,
	output logic                busy
);

	lgdd_pkg::upc_t       pc_q;
	lgdd_pkg::upc_t       pc_d;
	lgdd_pkg::ctrl_word_t cw;
	logic                 take;

	// Fetch the control word of the current step
	assign cw = lgdd_pkg::ucode(pc_q);

	// Next step: jump when the condition holds, else advance
	always_comb begin
		case (cw.cond)
			lgdd_pkg::C_NEVER:        take = 1'b0;
			lgdd_pkg::C_ALWAYS:       take = 1'b1;
			lgdd_pkg::C_NO_START:     take = !start;
			lgdd_pkg::C_REQ_OK:       take = flags.req_ok;
			lgdd_pkg::C_ALLOC_OK:     take = flags.alloc_ok;
			lgdd_pkg::C_DEALLOC_OK:   take = flags.dealloc_ok;
			lgdd_pkg::C_DETECT:       take = flags.detect;
			lgdd_pkg::C_CLEAR_OK:     take = flags.clear_ok;
			lgdd_pkg::C_SWEEP_MORE:   take = flags.sweep_more;
			lgdd_pkg::C_ROOT_END:     take = flags.root_end;
			lgdd_pkg::C_ROOT_DONE:    take = flags.root_done;
			lgdd_pkg::C_NO_SUCC:      take = flags.no_succ;
			lgdd_pkg::C_S_FRESH:      take = flags.s_fresh;
			lgdd_pkg::C_S_NOT_ACTIVE: take = flags.s_not_active;
			lgdd_pkg::C_TVAL_IS_S:    take = flags.tval_is_s;
			lgdd_pkg::C_IDX_ZERO:     take = flags.idx_zero;
			lgdd_pkg::C_D_ZERO:       take = flags.d_zero;
			default:                  take = 1'b0;
		endcase
		pc_d = take ? cw.target : pc_q + lgdd_pkg::upc_t'(1);
	end

	// Drive the datapath and the handshake
	always_comb begin
		op = cw.op;
		busy = (pc_q != lgdd_pkg::U_IDLE);
	end

	// Hold the step counter; start in the clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= lgdd_pkg::U_ZERO;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ----- src/lgdd_dp.sv -----
// Datapath: edge matrix RAM, DFS path stack, marks and recorded deadlock lock.
module lgdd_dp #(
	parameter int NUM_PROCS = lgdd_pkg::NUM_PROCS_DEF,
	parameter int NUM_LOCKS = lgdd_pkg::NUM_LOCKS_DEF,
	parameter int NUM_NODES = lgdd_pkg::NUM_NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lgdd_pkg::dp_op_t   op,
	input  lgdd_pkg::cmd_t     cmd,
	output lgdd_pkg::flags_t   flags,
	output logic               done,
	output lgdd_pkg::result_t  result
);

	localparam int NW  = $clog2(NUM_NODES);
	localparam int SW  = NW + 1;
	localparam int STW = NW + SW;
	localparam int LW  = lgdd_pkg::LOCK_W;

	function automatic logic [NUM_NODES-1:0] node_bit(input logic [NW-1:0] n);
		node_bit = NUM_NODES'(1) << n;
	endfunction

	// Latched command
	lgdd_pkg::cmd_t cmd_q;
	logic           pok;
	logic           lok;
	logic [NW-1:0]  pnode;
	logic [NW-1:0]  lnode;

	// Walk state
	logic [SW-1:0]        root_q;
	logic [NW-1:0]        root_idx;
	logic [NW-1:0]        d_q;
	logic [NW-1:0]        cur_node_q;
	logic [SW-1:0]        cur_scan_q;
	logic [NW-1:0]        succ_q;
	logic [NW-1:0]        idx_q;
	logic [NW-1:0]        tval_q;
	logic [NUM_NODES-1:0] done_marks_q;
	logic [NUM_NODES-1:0] active_marks_q;
	logic                 found_q;
	logic [LW-1:0]        rec_lock_q;
	logic                 rec_flag_q;
	logic                 done_q;
	lgdd_pkg::result_t    result_q;

	// Memories
	logic                 e_we;
	logic [NW-1:0]        e_waddr;
	logic [NUM_NODES-1:0] e_wdata;
	logic [NW-1:0]        e_raddr;
	logic [NUM_NODES-1:0] e_rdata;
	logic                 s_we;
	logic [NW-1:0]        s_waddr;
	logic [STW-1:0]       s_wdata;
	logic [NW-1:0]        s_raddr;
	logic [STW-1:0]       s_rdata;
	logic [NW-1:0]        st_node;
	logic [SW-1:0]        st_scan;

	// Successor search and cycle trace
	logic          succ_hit;
	logic [NW-1:0] succ_idx;
	logic [NW-1:0] touch_node;
	logic          touch_lock;
	logic [LW-1:0] touch_val;

	lgdd_ram #(.WIDTH(NUM_NODES), .DEPTH(NUM_NODES)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (e_waddr),
		.wdata (e_wdata),
		.raddr (e_raddr),
		.rdata (e_rdata)
	);

	lgdd_ram #(.WIDTH(STW), .DEPTH(NUM_NODES)) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	assign st_node  = s_rdata[STW-1:SW];
	assign st_scan  = s_rdata[SW-1:0];
	assign root_idx = root_q[NW-1:0];

	// Decode the latched command into node numbers
	always_comb begin
		pok   = (int'(cmd_q.proc_id) < NUM_PROCS) && (int'(cmd_q.proc_id) < NUM_NODES);
		lok   = (int'(cmd_q.lock_num) < NUM_LOCKS) &&
		        (NUM_PROCS + int'(cmd_q.lock_num) < NUM_NODES);
		pnode = NW'(cmd_q.proc_id);
		lnode = NW'(NUM_PROCS + int'(cmd_q.lock_num));
	end

	// Find the first successor at or after the scan position
	always_comb begin
		succ_hit = 1'b0;
		succ_idx = '0;
		for (int k = NUM_NODES - 1; k >= 0; k--) begin
			if (e_rdata[k] && (k >= int'(cur_scan_q))) begin
				succ_hit = 1'b1;
				succ_idx = NW'(k);
			end
		end
	end

	// Pick the node being touched by the cycle trace
	always_comb begin
		touch_node = (op == lgdd_pkg::OP_TOUCH_S) ? succ_q : tval_q;
		touch_lock = (int'(touch_node) >= NUM_PROCS);
		touch_val  = LW'(int'(touch_node) - NUM_PROCS);
	end

	// Status flags for the sequencer
	always_comb begin
		flags.req_ok       = (cmd_q.func == lgdd_pkg::FUNC_REQUEST) && pok && lok;
		flags.alloc_ok     = (cmd_q.func == lgdd_pkg::FUNC_ALLOCATE) && pok && lok;
		flags.dealloc_ok   = (cmd_q.func == lgdd_pkg::FUNC_DEALLOCATE) && pok && lok;
		flags.detect       = (cmd_q.func == lgdd_pkg::FUNC_DETECT);
		flags.clear_ok     = (cmd_q.func == lgdd_pkg::FUNC_CLEAR) && pok;
		flags.sweep_more   = (root_q != SW'(NUM_NODES - 1));
		flags.root_end     = (root_q == SW'(NUM_NODES));
		flags.root_done    = done_marks_q[root_idx];
		flags.no_succ      = !succ_hit;
		flags.s_fresh      = !done_marks_q[succ_q] && !active_marks_q[succ_q];
		flags.s_not_active = !active_marks_q[succ_q];
		flags.tval_is_s    = (tval_q == succ_q);
		flags.idx_zero     = (idx_q == '0);
		flags.d_zero       = (d_q == '0);
	end

	// Edge matrix ports: read-modify-write one row per op pair
	always_comb begin
		e_we    = 1'b0;
		e_waddr = pnode;
		e_wdata = '0;
		e_raddr = cur_node_q;
		case (op)
			lgdd_pkg::OP_ZERO_SWEEP: begin
				e_we    = 1'b1;
				e_waddr = root_idx;
			end
			lgdd_pkg::OP_RD_P:     e_raddr = pnode;
			lgdd_pkg::OP_RD_L:     e_raddr = lnode;
			lgdd_pkg::OP_RD_SWEEP: e_raddr = root_idx;
			lgdd_pkg::OP_RD_CUR:   e_raddr = cur_node_q;
			lgdd_pkg::OP_WR_P_SETL: begin
				e_we    = 1'b1;
				e_wdata = e_rdata | node_bit(lnode);
			end
			lgdd_pkg::OP_WR_P_CLRL: begin
				e_we    = 1'b1;
				e_wdata = e_rdata & ~node_bit(lnode);
			end
			lgdd_pkg::OP_WR_L_SETP: begin
				e_we    = 1'b1;
				e_waddr = lnode;
				e_wdata = e_rdata | node_bit(pnode);
			end
			lgdd_pkg::OP_WR_L_CLRP: begin
				e_we    = 1'b1;
				e_waddr = lnode;
				e_wdata = e_rdata & ~node_bit(pnode);
			end
			lgdd_pkg::OP_WR_SWEEP_CLRP: begin
				e_we    = 1'b1;
				e_waddr = root_idx;
				e_wdata = e_rdata & ~node_bit(pnode);
			end
			lgdd_pkg::OP_WR_P_ZERO: e_we = 1'b1;
			default: ;
		endcase
	end

	// Path stack ports: push the top on descent, read back on pop or trace
	always_comb begin
		s_we    = (op == lgdd_pkg::OP_PUSH);
		s_waddr = d_q;
		s_wdata = {cur_node_q, cur_scan_q};
		s_raddr = (op == lgdd_pkg::OP_RD_STACK) ? (idx_q - NW'(1)) : (d_q - NW'(1));
	end

	// Latch the command beat while idle
	always_ff @(posedge clk) begin
		if (op == lgdd_pkg::OP_LATCH) begin
			cmd_q <= cmd;
		end
	end

	// Walk state, marks, recorded lock and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q         <= '0;
			d_q            <= '0;
			cur_node_q     <= '0;
			cur_scan_q     <= '0;
			succ_q         <= '0;
			idx_q          <= '0;
			tval_q         <= '0;
			done_marks_q   <= '0;
			active_marks_q <= '0;
			found_q        <= 1'b0;
			rec_lock_q     <= '0;
			rec_flag_q     <= 1'b0;
			done_q         <= 1'b0;
			result_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (op)
				lgdd_pkg::OP_LATCH: found_q <= 1'b0;
				lgdd_pkg::OP_RESULT: begin
					done_q                <= 1'b1;
					result_q.cycle_found  <= found_q;
					result_q.victim_lock  <= rec_lock_q;
					result_q.victim_valid <= rec_flag_q;
				end
				lgdd_pkg::OP_ZERO_SWEEP:    root_q <= root_q + SW'(1);
				lgdd_pkg::OP_WR_SWEEP_CLRP: root_q <= root_q + SW'(1);
				lgdd_pkg::OP_SWEEP_INIT:    root_q <= '0;
				lgdd_pkg::OP_DET_INIT: begin
					done_marks_q   <= '0;
					active_marks_q <= '0;
					found_q        <= 1'b0;
					root_q         <= '0;
				end
				lgdd_pkg::OP_START_ROOT: begin
					d_q            <= '0;
					cur_node_q     <= root_idx;
					cur_scan_q     <= '0;
					active_marks_q <= active_marks_q | node_bit(root_idx);
				end
				lgdd_pkg::OP_SUCC: begin
					if (succ_hit) begin
						succ_q     <= succ_idx;
						cur_scan_q <= SW'(succ_idx) + SW'(1);
					end
				end
				lgdd_pkg::OP_TRACE_INIT: begin
					idx_q   <= d_q;
					tval_q  <= cur_node_q;
					found_q <= 1'b1;
				end
				lgdd_pkg::OP_TOUCH_TVAL, lgdd_pkg::OP_TOUCH_S: begin
					if (touch_lock) begin
						rec_lock_q <= touch_val;
						rec_flag_q <= 1'b1;
					end
				end
				lgdd_pkg::OP_RD_STACK:  idx_q <= idx_q - NW'(1);
				lgdd_pkg::OP_LOAD_TVAL: tval_q <= st_node;
				lgdd_pkg::OP_PUSH: begin
					d_q            <= d_q + NW'(1);
					cur_node_q     <= succ_q;
					cur_scan_q     <= '0;
					active_marks_q <= active_marks_q | node_bit(succ_q);
				end
				lgdd_pkg::OP_RETIRE: begin
					active_marks_q <= active_marks_q & ~node_bit(cur_node_q);
					done_marks_q   <= done_marks_q | node_bit(cur_node_q);
				end
				lgdd_pkg::OP_POP_RD: d_q <= d_q - NW'(1);
				lgdd_pkg::OP_POP_LOAD: begin
					cur_node_q <= st_node;
					cur_scan_q <= st_scan;
				end
				lgdd_pkg::OP_ROOT_INC: root_q <= root_q + SW'(1);
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- src/lock_graph_deadlock_detector.sv -----
// Top level of the lock graph deadlock detector.
//
// Keeps a process/lock allocation graph (processes are nodes 0..NUM_PROCS-1, lock k is
// node NUM_PROCS+k) and answers one command beat at a time: a beat is taken when start
// is high and busy is low, and exactly one result beat follows on result, marked by a
// one-cycle done strobe that cannot be held off. A microcoded sequencer steps a small
// datapath around one edge-matrix RAM port and one path-stack RAM port. Detect is a
// depth-first walk over the roots that skips roots already retired, scans each edge,
// pops nodes back off the path and, for each edge that closes a cycle, traces back to
// its target. After reset the block zeroes the edge matrix with busy high before it
// takes a command.
module lock_graph_deadlock_detector #(
	parameter int NUM_PROCS = lgdd_pkg::NUM_PROCS_DEF,
	parameter int NUM_LOCKS = lgdd_pkg::NUM_LOCKS_DEF,
	parameter int NUM_NODES = lgdd_pkg::NUM_NODES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lgdd_pkg::cmd_t    cmd,
	output logic              done,
	output lgdd_pkg::result_t result
);

	lgdd_pkg::dp_op_t op;
	lgdd_pkg::flags_t flags;

	// Step through the microcode program
	lgdd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.op     (op),
		.busy   (busy)
	);

	// Execute one datapath op per step
	lgdd_dp #(
		.NUM_PROCS (NUM_PROCS),
		.NUM_LOCKS (NUM_LOCKS),
		.NUM_NODES (NUM_NODES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.cmd    (cmd),
		.flags  (flags),
		.done   (done),
		.result (result)
	);

endmodule

// ----- src/lgdd_checker.sv -----
// Port-level checker for the lock graph deadlock detector, bound to the top level.
`include "assert_macros.svh"

module lgdd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input lgdd_pkg::result_t result
);

	// An accepted command beat keeps the block busy in the next cycle
	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// The result beat shows only once the sequencer is back at idle
	`ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)

	// One result beat per command: never two strobes in a row
	`ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)

	// Every cycle in the bipartite graph holds a lock, so a hit records one
	`ASSERT_IMPL(a_found_flag, clk, arst_n, done && result.cycle_found, result.victim_valid)

endmodule

bind lock_graph_deadlock_detector lgdd_checker u_lgdd_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ----- tb/tb_lock_graph_deadlock_detector.sv -----
// Self-checking bench for the lock graph deadlock detector: driver, monitor, predictor.
module tb_lock_graph_deadlock_detector;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PROCS  = lgdd_pkg::NUM_PROCS_DEF;
	localparam int NODES  = lgdd_pkg::NUM_NODES_DEF;
	localparam int FW     = lgdd_pkg::FUNC_W;
	localparam int LKW    = lgdd_pkg::LOCK_W;

	// Command codes the block does not use
	localparam logic [FW-1:0] FUNC_SPARE5 = 3'd5;
	localparam logic [FW-1:0] FUNC_SPARE6 = 3'd6;
	localparam logic [FW-1:0] FUNC_SPARE7 = 3'd7;

	localparam int RANDOM_ITEMS = 1300;
	localparam int CALM_FIRST   = 500;
	localparam int CALM_LAST    = 800;
	localparam int IDLE_PCT     = 9;
	localparam int DRAIN_CYCLES = 60;
	localparam int REPORT_MAX   = 10;
	localparam int CYCLE_LIMIT  = 40_000_000;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	lgdd_pkg::cmd_t    cmd    = '0;
	logic              busy;
	logic              done;
	lgdd_pkg::result_t result;

	lock_graph_deadlock_detector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted graph and sticky deadlock record
	logic [NODES-1:0] graph_adj [NODES];
	logic [LKW-1:0]   held_lock;
	logic             held_flag;

	lgdd_pkg::cmd_t    pending_cmds[$];
	lgdd_pkg::result_t expected_results[$];

	int beats_sent;
	int detect_beats;
	int cycles_seen;
	int mismatch_count;
	int cycle_count;
	int work_items;

	// Record a lock node met while tracing a cycle
	function automatic void note_node(input int n);
		if (n >= PROCS) begin
			held_lock = LKW'(n - PROCS);
			held_flag = 1'b1;
		end
	endfunction

	function automatic int first_succ(input int node, input int from);
		for (int k = from; k < NODES; k++)
			if (graph_adj[node][k])
				return k;
		return NODES;
	endfunction

	// Depth-first walk over all roots; every edge to an on-path node closes a cycle
	function automatic logic search_cycles();
		logic [NODES-1:0] retired;
		logic [NODES-1:0] on_path;
		int               path [NODES];
		int               scan [NODES];
		int               d;
		int               node;
		int               s;
		logic             found;
		logic             walking;
		retired = '0;
		on_path = '0;
		found = 1'b0;
		for (int root = 0; root < NODES; root++) begin
			if (retired[root])
				continue;
			d = 0;
			path[0] = root;
			scan[0] = 0;
			on_path[root] = 1'b1;
			walking = 1'b1;
			while (walking) begin
				node = path[d];
				s = first_succ(node, scan[d]);
				if (s >= NODES) begin
					// retire node and pop
					on_path[node] = 1'b0;
					retired[node] = 1'b1;
					if (d == 0)
						walking = 1'b0;
					else
						d--;
				end else begin
					scan[d] = s + 1;
					if (!retired[s] && !on_path[s]) begin
						d++;
						path[d] = s;
						scan[d] = 0;
						on_path[s] = 1'b1;
					end else if (on_path[s]) begin
						// trace from the current node back down to the target
						for (int k = d; k >= 0 && path[k] != s; k--)
							note_node(path[k]);
						note_node(s);
						found = 1'b1;
					end
				end
			end
		end
		return found;
	endfunction

	// Apply one command beat to the predicted graph and return its result
	function automatic lgdd_pkg::result_t apply_command(input lgdd_pkg::cmd_t c);
		lgdd_pkg::result_t r;
		int                p;
		int                l;
		logic              hit;
		// ids are 3 bits wide, so every process and lock node is in range here
		p = int'(c.proc_id);
		l = PROCS + int'(c.lock_num);
		hit = 1'b0;
		case (c.func)
			lgdd_pkg::FUNC_REQUEST: begin
				graph_adj[p][l] = 1'b1;
			end
			lgdd_pkg::FUNC_ALLOCATE: begin
				graph_adj[l][p] = 1'b1;
				graph_adj[p][l] = 1'b0;
			end
			lgdd_pkg::FUNC_DEALLOCATE: begin
				graph_adj[l][p] = 1'b0;
			end
			lgdd_pkg::FUNC_DETECT: begin
				hit = search_cycles();
			end
			lgdd_pkg::FUNC_CLEAR: begin
				graph_adj[p] = '0;
				for (int k = 0; k < NODES; k++)
					graph_adj[k][p] = 1'b0;
			end
			default: begin
			end
		endcase
		r.cycle_found = hit;
		r.victim_lock = held_lock;
		r.victim_valid = held_flag;
		return r;
	endfunction

	task automatic add_cmd(input logic [FW-1:0] f, input int p, input int l);
		lgdd_pkg::cmd_t c;
		c.func = f;
		c.proc_id = lgdd_pkg::ID_W'(p);
		c.lock_num = LKW'(l);
		pending_cmds.push_back(c);
		if (f <= lgdd_pkg::FUNC_CLEAR)
			work_items++;
	endtask

	// Drive command beats; hold a presented beat until busy drops
	always @(posedge clk or negedge arst_n) begin : drive_cmds
		logic hold_off;
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(apply_command(cmd));
				if (cmd.func == lgdd_pkg::FUNC_DETECT)
					detect_beats++;
				beats_sent++;
			end
			if (!start || !busy) begin
				hold_off = !(beats_sent >= CALM_FIRST && beats_sent < CALM_LAST) &&
					($urandom_range(0, 99) < IDLE_PCT);
				if (pending_cmds.size() != 0 && !hold_off) begin
					cmd <= pending_cmds.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin : watch_results
		lgdd_pkg::result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected result beat: found=%0b lock=%0d valid=%0b",
						result.cycle_found, result.victim_lock, result.victim_valid);
			end else begin
				want = expected_results.pop_front();
				if (result.cycle_found !== want.cycle_found ||
					result.victim_lock !== want.victim_lock ||
					result.victim_valid !== want.victim_valid) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display({"mismatch: found exp %0b got %0b, lock exp %0d got %0d, ",
							"valid exp %0b got %0b"},
							want.cycle_found, result.cycle_found,
							want.victim_lock, result.victim_lock,
							want.victim_valid, result.victim_valid);
				end
			end
			if (result.cycle_found === 1'b1)
				cycles_seen++;
		end
	end

	// Guard against a hang
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[lock_graph_deadlock_detector] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int   ring_p [6];
		int   ring_l [6];
		int   n;
		int   roll;
		int   goal;
		logic failed;
		for (int k = 0; k < NODES; k++)
			graph_adj[k] = '0;
		held_lock = '0;
		held_flag = 1'b0;

		// Directed: empty graph, a four-node cycle, spare codes, a two-node cycle
		add_cmd(lgdd_pkg::FUNC_DETECT, 0, 0);
		add_cmd(lgdd_pkg::FUNC_REQUEST, 0, 0);
		add_cmd(lgdd_pkg::FUNC_ALLOCATE, 1, 0);
		add_cmd(lgdd_pkg::FUNC_REQUEST, 1, 7);
		add_cmd(lgdd_pkg::FUNC_ALLOCATE, 0, 7);
		add_cmd(lgdd_pkg::FUNC_DETECT, 0, 0);
		add_cmd(FUNC_SPARE5, 7, 7);
		add_cmd(FUNC_SPARE6, 0, 0);
		add_cmd(FUNC_SPARE7, 5, 2);
		add_cmd(lgdd_pkg::FUNC_DEALLOCATE, 0, 7);
		add_cmd(lgdd_pkg::FUNC_DETECT, 0, 0);
		add_cmd(lgdd_pkg::FUNC_REQUEST, 7, 7);
		add_cmd(lgdd_pkg::FUNC_ALLOCATE, 7, 0);
		add_cmd(lgdd_pkg::FUNC_CLEAR, 0, 0);
		add_cmd(lgdd_pkg::FUNC_CLEAR, 1, 0);
		add_cmd(lgdd_pkg::FUNC_CLEAR, 7, 0);
		add_cmd(lgdd_pkg::FUNC_ALLOCATE, 3, 3);
		add_cmd(lgdd_pkg::FUNC_REQUEST, 3, 3);
		add_cmd(lgdd_pkg::FUNC_DETECT, 0, 0);
		add_cmd(lgdd_pkg::FUNC_CLEAR, 3, 0);
		add_cmd(lgdd_pkg::FUNC_DETECT, 7, 7);

		// Random: mostly lock rings that may close, plus noise and full wipes
		goal = work_items + RANDOM_ITEMS;
		while (work_items < goal) begin
			roll = $urandom_range(0, 99);
			if (roll < 60) begin
				n = $urandom_range(2, 6);
				for (int i = 0; i < n; i++) begin
					ring_p[i] = $urandom_range(0, PROCS - 1);
					ring_l[i] = $urandom_range(0, 7);
					add_cmd(lgdd_pkg::FUNC_ALLOCATE, ring_p[i], ring_l[i]);
				end
				for (int i = 0; i < n; i++)
					if ($urandom_range(0, 9) != 0)
						add_cmd(lgdd_pkg::FUNC_REQUEST, ring_p[i], ring_l[(i + 1) % n]);
				if ($urandom_range(0, 3) == 0)
					add_cmd(lgdd_pkg::FUNC_DEALLOCATE, ring_p[0], ring_l[0]);
				add_cmd(lgdd_pkg::FUNC_DETECT, $urandom_range(0, 7), $urandom_range(0, 7));
				for (int i = $urandom_range(0, n); i > 0; i--)
					add_cmd(lgdd_pkg::FUNC_CLEAR, $urandom_range(0, PROCS - 1),
						$urandom_range(0, 7));
			end else if (roll < 92) begin
				add_cmd(FW'($urandom_range(0, 7)), $urandom_range(0, 7),
					$urandom_range(0, 7));
			end else begin
				for (int p = 0; p < PROCS; p++)
					add_cmd(lgdd_pkg::FUNC_CLEAR, p, $urandom_range(0, 7));
				add_cmd(lgdd_pkg::FUNC_DETECT, 0, 0);
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all beats sent, all results back, then let the block settle
		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		failed = (mismatch_count != 0) || (expected_results.size() != 0);
		$display("ran %0d command beats over %0d cycles; %0d detects, %0d found a deadlock cycle",
			beats_sent, cycle_count, detect_beats, cycles_seen);
		if (!failed)
			$display("[lock_graph_deadlock_detector] OK");
		else
			$display("[lock_graph_deadlock_detector] ERROR");
		$finish;
	end

endmodule
